### hdl/bdc_pkg.sv
`default_nettype none

package bdc_pkg;

  // width of the saturating press-duration counter
  localparam int unsigned TimerBits = 16;
  localparam int unsigned TickBits  = 16;
  // common width for comparing the press counter against click_ticks
  localparam int unsigned CmpBits   = (TimerBits > TickBits) ? TimerBits : TickBits;

  localparam logic [TimerBits-1:0] ElapsedMax = {TimerBits{1'b1}};

  // configuration register indexes
  localparam logic CfgDebounceTicks = 1'b0;
  localparam logic CfgClickTicks    = 1'b1;

  localparam logic [TickBits-1:0] DebounceTicksRst = TickBits'(10);
  localparam logic [TickBits-1:0] ClickTicksRst    = TickBits'(100);

  typedef struct packed {
    logic                 held_level;
    logic [TickBits-1:0]  debounce_left;
    logic                 debounce_armed;
    logic                 button_down;
    logic [TimerBits-1:0] press_elapsed;
    logic                 press_open;
  } state_t;

  typedef struct packed {
    logic click_pulse;
    logic state_changed;
    logic pressed;
  } result_t;

  localparam state_t StateRst = '{
    held_level:     1'b1,
    debounce_left:  '0,
    debounce_armed: 1'b0,
    button_down:    1'b0,
    press_elapsed:  '0,
    press_open:     1'b0
  };

endpackage

`default_nettype wire

### hdl/bdc_step.sv
`default_nettype none

module bdc_step (
  input  var bdc_pkg::state_t                  state_i,
  input  var logic                             pin_level_i,
  input  var logic [bdc_pkg::TickBits-1:0]     debounce_ticks_i,
  input  var logic [bdc_pkg::TickBits-1:0]     click_ticks_i,
  output bdc_pkg::state_t                      state_o,
  output bdc_pkg::result_t                     result_o
);

  logic expired;
  logic now_down;
  logic short_press;

  always_comb begin
    state_o     = state_i;
    result_o    = '0;
    expired     = 1'b0;
    now_down    = 1'b0;
    short_press = 1'b0;

    if (state_i.press_open && (state_i.press_elapsed != bdc_pkg::ElapsedMax)) begin
      state_o.press_elapsed = state_i.press_elapsed + 1'b1;
    end

    if (pin_level_i != state_i.held_level) begin
      state_o.held_level     = pin_level_i;
      state_o.debounce_left  = debounce_ticks_i;
      state_o.debounce_armed = 1'b1;
    end else if (state_i.debounce_armed) begin
      if (state_i.debounce_left <= bdc_pkg::TickBits'(1)) begin
        state_o.debounce_left = '0;
        expired               = 1'b1;
      end else begin
        state_o.debounce_left = state_i.debounce_left - 1'b1;
      end
    end

    if (expired) begin
      now_down               = ~state_o.held_level;
      state_o.debounce_armed = 1'b0;
      if (now_down != state_i.button_down) begin
        state_o.button_down    = now_down;
        result_o.state_changed = 1'b1;
        if (now_down) begin
          state_o.press_elapsed = '0;
          state_o.press_open    = 1'b1;
        end else begin
          // release counts as click only for an open, unsaturated, short press
          short_press = (state_o.press_elapsed != bdc_pkg::ElapsedMax) &&
                        (bdc_pkg::CmpBits'(state_o.press_elapsed) <=
                         bdc_pkg::CmpBits'(click_ticks_i));
          result_o.click_pulse = state_i.press_open && short_press;
          state_o.press_open   = 1'b0;
        end
      end
    end

    result_o.pressed = state_o.button_down;
  end

endmodule

`default_nettype wire

### hdl/button_debounce_click_detector_core.sv
// a tick accepted into the input register moves on to the result register only
// when the result stage can advance, so an output stall holds it there
// throughput: one tick per cycle while the output does not stall; one result per tick
// the tick is captured in an input register, the next state and result come
// from one pass of compare and count logic into the result register
// reset (asynchronous, active low): registers back to 10 and 100 ticks,
// held level high, countdown idle, button released, no press pending
`default_nettype none

module button_debounce_click_detector_core (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  // configuration write port
  input  var logic        cfg_we_i,
  input  var logic        cfg_idx_i,
  input  var logic [15:0] cfg_data_i,
  // tick stream in
  input  var logic        s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  var logic [7:0]  s_axis_tdata_i,   // [0] pin_level, [7:1] zero
  // result stream out
  output logic            m_axis_tvalid_o,
  input  var logic        m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [0] pressed, [1] state_changed,
                                            // [2] click_pulse, [7:3] zero
);

  // configuration registers
  logic [bdc_pkg::TickBits-1:0] debounce_ticks_q;
  logic [bdc_pkg::TickBits-1:0] click_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= bdc_pkg::DebounceTicksRst;
      click_ticks_q    <= bdc_pkg::ClickTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdc_pkg::CfgDebounceTicks: debounce_ticks_q <= cfg_data_i;
        bdc_pkg::CfgClickTicks:    click_ticks_q    <= cfg_data_i;
        default:                   ;
      endcase
    end
  end

  // input register stage
  logic in_vld_q, in_vld_d;
  logic pin_q;
  logic in_take;
  logic advance;

  // result stage moves when empty or being drained this cycle
  assign advance         = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pin_q <= s_axis_tdata_i[0];
    end
  end

  // debounce / click state and per-tick update
  bdc_pkg::state_t  state_q, state_d;
  bdc_pkg::result_t res_d, res_q;
  logic             out_vld_q;
  logic             fire;

  bdc_step u_step (
    .state_i          (state_q),
    .pin_level_i      (pin_q),
    .debounce_ticks_i (debounce_ticks_q),
    .click_ticks_i    (click_ticks_q),
    .state_o          (state_d),
    .result_o         (res_d)
  );

  assign fire = in_vld_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bdc_pkg::StateRst;
      out_vld_q <= 1'b0;
    end else if (fire) begin
      state_q   <= state_d;
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, res_q.click_pulse, res_q.state_changed, res_q.pressed};

  // a click only comes with a release transition
  a_click_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_q.click_pulse) |-> (res_q.state_changed && !res_q.pressed))
    else $error("click pulse without a release");

  // a press is pending exactly while the debounced button is down
  a_press_tracks_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.press_open == state_q.button_down)
    else $error("press_open out of step with button_down");

  // a nonzero countdown only exists while it is armed
  a_countdown_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.debounce_left != '0) |-> state_q.debounce_armed)
    else $error("debounce countdown running while not armed");

endmodule

`default_nettype wire

### sim/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // tracks the debounced button exactly as the block should, one tick at a time,
  // and holds the results still owed by the block in arrival order
  class button_tracker;
    logic [bdc_pkg::TickBits-1:0] debounce_ticks = bdc_pkg::DebounceTicksRst;
    logic [bdc_pkg::TickBits-1:0] click_ticks    = bdc_pkg::ClickTicksRst;
    bdc_pkg::state_t              st             = bdc_pkg::StateRst;
    bdc_pkg::result_t             due_results[$];
    int unsigned                  failures       = 0;

    function void set_reg(logic idx, logic [15:0] value);
      if (idx == bdc_pkg::CfgDebounceTicks) begin
        debounce_ticks = value;
      end else begin
        click_ticks = value;
      end
    endfunction

    // advance the tracked state by one accepted tick
    function void note_tick(logic level);
      logic             expired;
      logic             now_down;
      bdc_pkg::result_t res;
      expired = 1'b0;
      res     = '0;
      // an open press counts up first, stopping at the top
      if (st.press_open && st.press_elapsed != bdc_pkg::ElapsedMax) begin
        st.press_elapsed = st.press_elapsed + 1'b1;
      end
      // a new level restarts the countdown, otherwise an armed countdown runs down
      if (level != st.held_level) begin
        st.held_level     = level;
        st.debounce_left  = debounce_ticks;
        st.debounce_armed = 1'b1;
      end else if (st.debounce_armed) begin
        if (st.debounce_left <= 16'd1) begin
          st.debounce_left = '0;
          expired          = 1'b1;
        end else begin
          st.debounce_left = st.debounce_left - 1'b1;
        end
      end
      if (expired) begin
        now_down          = (st.held_level == 1'b0);
        st.debounce_armed = 1'b0;
        if (now_down != st.button_down) begin
          st.button_down    = now_down;
          res.state_changed = 1'b1;
          if (now_down) begin
            st.press_elapsed = '0;
            st.press_open    = 1'b1;
          end else begin
            // short press ends in a click, a saturated one never does
            res.click_pulse = st.press_open && st.press_elapsed != bdc_pkg::ElapsedMax &&
                              bdc_pkg::CmpBits'(st.press_elapsed) <=
                              bdc_pkg::CmpBits'(click_ticks);
            st.press_open   = 1'b0;
          end
        end
      end
      res.pressed = st.button_down;
      due_results.push_back(res);
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0b, got %0b", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [7:0] data);
      bdc_pkg::result_t want;
      bdc_pkg::result_t got;
      got = bdc_pkg::result_t'(data[2:0]);
      if (due_results.size() == 0) begin
        $error("result transaction with no tick waiting: %02h", data);
        failures++;
        return;
      end
      want = due_results.pop_front();
      compare_bit("pressed", want.pressed, got.pressed);
      compare_bit("state_changed", want.state_changed, got.state_changed);
      compare_bit("click_pulse", want.click_pulse, got.click_pulse);
    endfunction
  endclass

  // dut connections, all inputs known from time zero
  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we          = 1'b0;
  logic        cfg_idx         = bdc_pkg::CfgDebounceTicks;
  logic [15:0] cfg_data        = '0;
  logic        s_tvalid        = 1'b0;
  logic [7:0]  s_tdata         = '0;
  logic        m_tready        = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;

  button_tracker tracker = new;

  // stimulus bookkeeping
  int unsigned ticks_sent   = 0;
  int unsigned results_seen = 0;
  bit          quiet        = 1'b0;   // no idling on either side while set
  bit          hold_off_done = 1'b0;

  button_debounce_click_detector_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offer one tick, with a random gap in front, and wait for its transaction
  task automatic send_tick(input logic level);
    while (!quiet && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, level};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tracker.note_tick(level);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic level, input int unsigned count);
    repeat (count) send_tick(level);
  endtask

  // ticks written as a string of pin levels, first tick leftmost
  task automatic send_pattern(input string levels);
    for (int i = 0; i < levels.len(); i++) begin
      send_tick(levels[i] == "1");
    end
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // both registers, written on back-to-back edges while the block is idle
  task automatic apply_setting(input logic [15:0] debounce, input logic [15:0] click);
    cfg_we   <= 1'b1;
    cfg_idx  <= bdc_pkg::CfgDebounceTicks;
    cfg_data <= debounce;
    @(posedge clk_i);
    tracker.set_reg(bdc_pkg::CfgDebounceTicks, debounce);
    cfg_idx  <= bdc_pkg::CfgClickTicks;
    cfg_data <= click;
    @(posedge clk_i);
    tracker.set_reg(bdc_pkg::CfgClickTicks, click);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // a few ticks of contact bounce, each run shorter than the debounce time
  task automatic bounce(input int unsigned debounce);
    repeat ($urandom_range(0, 3)) begin
      hold_level(1'($urandom_range(0, 1)), $urandom_range(1, debounce));
    end
  endtask

  // one press and release with bounce around both edges, or a burst of noise
  task automatic press_or_noise(input int unsigned debounce, input int unsigned click);
    int unsigned d;
    int unsigned lim;
    d   = (debounce == 0) ? 1 : debounce;
    // keep presses short when the click limit is large
    lim = (click > 40) ? 40 : click;
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
    end else begin
      bounce(d);
      // duration around the click limit so both outcomes show up
      hold_level(1'b0, d + $urandom_range(0, lim + d + 4));
      bounce(d);
      hold_level(1'b1, d + $urandom_range(0, 2 * d + 3));
    end
  endtask

  task automatic run_random(input logic [15:0] debounce, input logic [15:0] click,
                            input int unsigned count);
    int unsigned start;
    start = ticks_sent;
    apply_setting(debounce, click);
    while (ticks_sent - start < count) press_or_noise(32'(debounce), 32'(click));
    drain();
  endtask

  // result side: random stalls, plus one long hold-off to back up the input
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_off_done && results_seen >= 60) begin
        hold_off_done = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      m_tready <= quiet || ($urandom_range(0, 99) >= 30);
    end
  end

  // every result transaction is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      tracker.check_result(m_axis_tdata_o);
      results_seen++;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings (10, 100) without any write first
    while (ticks_sent < 120) press_or_noise(10, 100);
    drain();

    // directed: clean press released just past the click limit, glitch that never expires, long press
    apply_setting(16'd2, 16'd3);
    send_pattern("10000111");
    send_pattern("0110");
    send_pattern("00000000111");
    drain();

    // debounce of zero acts like one, click limit of zero never clicks
    apply_setting(16'd0, 16'd0);
    send_pattern("00110");
    drain();

    // random phases, the third one without any idling
    run_random(16'd1, 16'd0, 40);
    run_random(16'd1, 16'hFFFF, 40);
    quiet = 1'b1;
    run_random(16'd3, 16'd8, 60);
    quiet = 1'b0;
    run_random(16'd5, 16'd20, 40);
    run_random(16'd2, 16'd2, 40);
    run_random(16'($urandom_range(1, 8)), 16'($urandom_range(0, 30)), 40);

    // widest settings: the long countdown keeps the debounced state still
    apply_setting(16'hFFFF, 16'hFFFF);
    send_pattern("0000000011111111");
    drain();

    run_random(16'd4, 16'd12, 40);

    repeat (20) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
